### sv/ldf_pkg.sv
// Shared types and constants for the labeled frame deframer.
`default_nettype none

package ldf_pkg;

	localparam int BYTE_W = 8;
	localparam int IDX_W  = 10;
	localparam int LEN_W  = 16;
	localparam int FLEN_W = 10;
	localparam int CFG_IDX_W = 1;

	// Command codes on the input channel
	localparam logic CMD_LINK = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Result kinds on the output channel
	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 1'b1;

	localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd126;
	localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd231;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LABEL,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_BODY,
		PH_END
	} phase_t;

	// Completed-frame event from the parser
	typedef struct packed {
		logic              done;
		logic [BYTE_W-1:0] label;
		logic [FLEN_W-1:0] length;
	} frame_evt_t;

endpackage

`default_nettype wire

### sv/ldf_if.sv
// Handshake channel interfaces: input words, result words and configuration writes.
`default_nettype none

interface ldf_in_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [ldf_pkg::BYTE_W-1:0]    rx_byte;
	logic [ldf_pkg::IDX_W-1:0]     read_index;

	modport source (output valid, command, rx_byte, read_index, input ready);
	modport sink   (input valid, command, rx_byte, read_index, output ready);
endinterface

interface ldf_out_if;
	logic                          valid;
	logic                          ready;
	logic                          result_kind;
	logic [ldf_pkg::BYTE_W-1:0]    frame_label;
	logic [ldf_pkg::FLEN_W-1:0]    frame_length;
	logic [ldf_pkg::BYTE_W-1:0]    read_byte;

	modport source (output valid, result_kind, frame_label, frame_length, read_byte,
		input ready);
	modport sink   (input valid, result_kind, frame_label, frame_length, read_byte,
		output ready);
endinterface

interface ldf_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ldf_pkg::CFG_IDX_W-1:0]   index;
	logic [ldf_pkg::BYTE_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/ldf_parser.sv
// Frame parser: phase state machine, label, length and body counter.
`default_nettype none

module ldf_parser #(
	parameter int MAX_BODY = 600
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          byte_en,
	input  wire logic [ldf_pkg::BYTE_W-1:0]    rx_byte,
	input  wire logic [ldf_pkg::BYTE_W-1:0]    start_marker,
	input  wire logic [ldf_pkg::BYTE_W-1:0]    end_marker,
	output logic                               wr_en,
	output logic [((MAX_BODY > 1) ? $clog2(MAX_BODY) : 1)-1:0] wr_addr,
	output logic [ldf_pkg::BYTE_W-1:0]         wr_data,
	output ldf_pkg::frame_evt_t                evt
);

	localparam int ADDR_W = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
	localparam int CNT_W  = $clog2(MAX_BODY + 1);
	localparam int CMP_W  = ldf_pkg::LEN_W + 1;

	ldf_pkg::phase_t                 phase_q, phase_d;
	logic [ldf_pkg::BYTE_W-1:0]      label_q, label_d;
	logic [ldf_pkg::LEN_W-1:0]       length_q, length_d;
	logic [CNT_W-1:0]                count_q, count_d;
	logic [ldf_pkg::LEN_W-1:0]       len_full;
	logic [CNT_W-1:0]                count_inc;

	assign len_full  = {rx_byte, length_q[ldf_pkg::BYTE_W-1:0]};
	assign count_inc = count_q + CNT_W'(1);

	// Hold state between words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ldf_pkg::PH_HUNT;
			label_q  <= '0;
			length_q <= '0;
			count_q  <= '0;
		end else if (byte_en) begin
			phase_q  <= phase_d;
			label_q  <= label_d;
			length_q <= length_d;
			count_q  <= count_d;
		end
	end

	// Advance the parse by one link byte
	always_comb begin
		phase_d    = phase_q;
		label_d    = label_q;
		length_d   = length_q;
		count_d    = count_q;
		wr_en      = 1'b0;
		wr_addr    = count_q[ADDR_W-1:0];
		wr_data    = rx_byte;
		evt.done   = 1'b0;
		evt.label  = label_q;
		evt.length = length_q[ldf_pkg::FLEN_W-1:0];
		case (phase_q)
			ldf_pkg::PH_HUNT: begin
				if (rx_byte == start_marker) begin
					phase_d = ldf_pkg::PH_LABEL;
				end
			end
			ldf_pkg::PH_LABEL: begin
				label_d = rx_byte;
				phase_d = ldf_pkg::PH_LEN_LO;
			end
			ldf_pkg::PH_LEN_LO: begin
				length_d = {{(ldf_pkg::LEN_W - ldf_pkg::BYTE_W){1'b0}}, rx_byte};
				phase_d  = ldf_pkg::PH_LEN_HI;
			end
			ldf_pkg::PH_LEN_HI: begin
				length_d = len_full;
				count_d  = '0;
				if (len_full == '0) begin
					phase_d = ldf_pkg::PH_END;
				end else if (CMP_W'(len_full) > CMP_W'(MAX_BODY)) begin
					phase_d = ldf_pkg::PH_HUNT;
				end else begin
					phase_d = ldf_pkg::PH_BODY;
				end
			end
			ldf_pkg::PH_BODY: begin
				wr_en   = byte_en && (CMP_W'(count_q) < CMP_W'(MAX_BODY));
				count_d = count_inc;
				if (CMP_W'(count_inc) >= CMP_W'(length_q)) begin
					phase_d = ldf_pkg::PH_END;
				end
			end
			ldf_pkg::PH_END: begin
				phase_d  = ldf_pkg::PH_HUNT;
				evt.done = (rx_byte == end_marker);
			end
			default: begin
				phase_d = ldf_pkg::PH_HUNT;
			end
		endcase
	end

endmodule

`default_nettype wire

### sv/ldf_body_ram.sv
// Body byte store: one write port, one read port with registered data.
`default_nettype none

module ldf_body_ram #(
	parameter int MAX_BODY = 600
) (
	input  wire logic                          clk,
	input  wire logic                          wr_en,
	input  wire logic [((MAX_BODY > 1) ? $clog2(MAX_BODY) : 1)-1:0] wr_addr,
	input  wire logic [ldf_pkg::BYTE_W-1:0]    wr_data,
	input  wire logic                          rd_en,
	input  wire logic [((MAX_BODY > 1) ? $clog2(MAX_BODY) : 1)-1:0] rd_addr,
	output logic [ldf_pkg::BYTE_W-1:0]         rd_data_q
);

	logic [ldf_pkg::BYTE_W-1:0] mem [MAX_BODY];

	// Store body bytes
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Fetch and hold read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### sv/labeled_frame_deframer_unit.sv
// Labeled frame deframer top level: config registers, parser, body store, result register.
// Latency: a result word appears on the cycle after the input word that causes it.
// Throughput: one input word per cycle; the single result register stalls input only
// while a result waits and the sink is not ready.
// Reset clears the parse to start-byte hunting and loads the marker reset values;
// the body store is not cleared and needs no sweep after reset.
`default_nettype none

module labeled_frame_deframer_unit #(
	parameter int MAX_BODY = 600
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ldf_in_if.sink     items,
	ldf_out_if.source  results,
	ldf_cfg_if.sink    cfg
);

	localparam int ADDR_W  = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
	localparam int IDX_EXT = (ADDR_W > ldf_pkg::IDX_W) ? ADDR_W : ldf_pkg::IDX_W;
	localparam int CMP_W   = ldf_pkg::LEN_W + 1;

	logic [ldf_pkg::BYTE_W-1:0]  start_marker_q;
	logic [ldf_pkg::BYTE_W-1:0]  end_marker_q;

	logic                        accept;
	logic                        byte_en;
	logic                        read_en;
	logic                        wr_en;
	logic [ADDR_W-1:0]           wr_addr;
	logic [ldf_pkg::BYTE_W-1:0]  wr_data;
	logic [IDX_EXT-1:0]          idx_ext;
	logic                        idx_ok;
	logic [ldf_pkg::BYTE_W-1:0]  rd_data_q;
	ldf_pkg::frame_evt_t         evt;

	logic                        out_valid_q;
	logic                        kind_q;
	logic [ldf_pkg::BYTE_W-1:0]  label_q;
	logic [ldf_pkg::FLEN_W-1:0]  length_q;
	logic                        idx_ok_q;

	assign cfg.ready   = 1'b1;
	assign items.ready = !out_valid_q || results.ready;
	assign accept      = items.valid && items.ready;
	assign byte_en     = accept && (items.command == ldf_pkg::CMD_LINK);
	assign read_en     = accept && (items.command == ldf_pkg::CMD_READ);
	assign idx_ext     = IDX_EXT'(items.read_index);
	assign idx_ok      = CMP_W'(items.read_index) < CMP_W'(MAX_BODY);

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= ldf_pkg::START_MARKER_RST;
			end_marker_q   <= ldf_pkg::END_MARKER_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				ldf_pkg::REG_START_MARKER: start_marker_q <= cfg.data;
				ldf_pkg::REG_END_MARKER:   end_marker_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	ldf_parser #(
		.MAX_BODY (MAX_BODY)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_en      (byte_en),
		.rx_byte      (items.rx_byte),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.evt          (evt)
	);

	ldf_body_ram #(
		.MAX_BODY (MAX_BODY)
	) u_body_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (read_en && idx_ok),
		.rd_addr   (idx_ext[ADDR_W-1:0]),
		.rd_data_q (rd_data_q)
	);

	// Result valid: load on a new result word, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (read_en || (byte_en && evt.done)) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (read_en) begin
			kind_q   <= ldf_pkg::KIND_READ;
			label_q  <= '0;
			length_q <= '0;
			idx_ok_q <= idx_ok;
		end else if (byte_en && evt.done) begin
			kind_q   <= ldf_pkg::KIND_FRAME;
			label_q  <= evt.label;
			length_q <= evt.length;
			idx_ok_q <= 1'b0;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.result_kind  = kind_q;
	assign results.frame_label  = label_q;
	assign results.frame_length = length_q;
	assign results.read_byte    = ((kind_q == ldf_pkg::KIND_READ) && idx_ok_q) ?
		rd_data_q : '0;

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the labeled frame deframer: directed and random traffic.
`timescale 1ns / 100ps

module testbench;

	localparam int MAX_BODY     = 600;
	localparam int IDX_TOP      = (1 << ldf_pkg::IDX_W) - 1;
	localparam int DRAIN_CYCLES = 4;

	typedef struct packed {
		logic                       kind;
		logic [ldf_pkg::BYTE_W-1:0] label;
		logic [ldf_pkg::FLEN_W-1:0] length;
		logic [ldf_pkg::BYTE_W-1:0] rbyte;
	} result_t;

	logic clk;
	logic arst_n;

	ldf_in_if  items_ch ();
	ldf_out_if results_ch ();
	ldf_cfg_if cfg_ch ();

	labeled_frame_deframer_unit #(
		.MAX_BODY(MAX_BODY)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_ch),
		.results(results_ch),
		.cfg    (cfg_ch)
	);

	// Deframer state as the testbench sees it
	logic [ldf_pkg::BYTE_W-1:0] start_mk;
	logic [ldf_pkg::BYTE_W-1:0] end_mk;
	ldf_pkg::phase_t            ph;
	logic [ldf_pkg::BYTE_W-1:0] lbl;
	logic [ldf_pkg::LEN_W-1:0]  len;
	int                         cnt;
	logic [ldf_pkg::BYTE_W-1:0] body_mem [MAX_BODY];
	bit                         written [MAX_BODY];
	int                         written_idx [$];

	result_t                    pending [$];
	logic [ldf_pkg::BYTE_W-1:0] frame_q [$];

	int  err_count;
	int  words_sent;
	int  frames_seen;
	int  reads_seen;
	int  frames_dropped;
	int  settings_run;
	int  burst_left;
	bit  idle_on;
	int  read_pct;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Give up after a generous fixed time
	initial begin
		#4_000_000;
		$display("testbench: timeout at %0t", $time);
		$display("testbench: done, errors");
		$finish;
	end

	function automatic logic [ldf_pkg::BYTE_W-1:0] rand_byte();
		return ldf_pkg::BYTE_W'($urandom_range(0, 255));
	endfunction

	// Pick a read position: a written entry, or an index past the end of the store
	function automatic logic [ldf_pkg::IDX_W-1:0] pick_read_index();
		if (written_idx.size() == 0 || $urandom_range(0, 5) == 0)
			return ldf_pkg::IDX_W'($urandom_range(MAX_BODY, IDX_TOP));
		return ldf_pkg::IDX_W'(written_idx[$urandom_range(0, written_idx.size() - 1)]);
	endfunction

	// Advance the predicted parse by one accepted word and queue any result
	task automatic deframe_step(input logic cmd, input logic [ldf_pkg::BYTE_W-1:0] b,
			input logic [ldf_pkg::IDX_W-1:0] idx);
		result_t r;
		r = '0;
		if (cmd == ldf_pkg::CMD_READ) begin
			r.kind = ldf_pkg::KIND_READ;
			if (idx < MAX_BODY)
				r.rbyte = body_mem[idx];
			pending.push_back(r);
		end else begin
			case (ph)
				ldf_pkg::PH_HUNT: begin
					if (b == start_mk)
						ph = ldf_pkg::PH_LABEL;
				end
				ldf_pkg::PH_LABEL: begin
					lbl = b;
					ph  = ldf_pkg::PH_LEN_LO;
				end
				ldf_pkg::PH_LEN_LO: begin
					len = {8'h00, b};
					ph  = ldf_pkg::PH_LEN_HI;
				end
				ldf_pkg::PH_LEN_HI: begin
					len = {b, len[7:0]};
					cnt = 0;
					if (len == 0) begin
						ph = ldf_pkg::PH_END;
					end else if (len > MAX_BODY) begin
						ph = ldf_pkg::PH_HUNT;
						frames_dropped++;
					end else begin
						ph = ldf_pkg::PH_BODY;
					end
				end
				ldf_pkg::PH_BODY: begin
					if (cnt < MAX_BODY) begin
						body_mem[cnt] = b;
						if (!written[cnt]) begin
							written[cnt] = 1'b1;
							written_idx.push_back(cnt);
						end
					end
					cnt++;
					if (cnt >= len)
						ph = ldf_pkg::PH_END;
				end
				ldf_pkg::PH_END: begin
					ph = ldf_pkg::PH_HUNT;
					if (b == end_mk) begin
						r.kind   = ldf_pkg::KIND_FRAME;
						r.label  = lbl;
						r.length = len[ldf_pkg::FLEN_W-1:0];
						pending.push_back(r);
					end else begin
						frames_dropped++;
					end
				end
				default: ph = ldf_pkg::PH_HUNT;
			endcase
		end
	endtask

	// Send one word; idle between bursts when idle gaps are on, hold until accepted
	task automatic send_word(input logic cmd, input logic [ldf_pkg::BYTE_W-1:0] b,
			input logic [ldf_pkg::IDX_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = idle_on ? $urandom_range(1, 8) : 0;
			if (gap > 0) begin
				items_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		items_ch.valid      <= 1'b1;
		items_ch.command    <= cmd;
		items_ch.rx_byte    <= b;
		items_ch.read_index <= idx;
		do @(posedge clk); while (!items_ch.ready);
		deframe_step(cmd, b, idx);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_read(input logic [ldf_pkg::IDX_W-1:0] idx);
		send_word(ldf_pkg::CMD_READ, rand_byte(), idx);
	endtask

	// Send one link byte, now and then preceded by a buffer read
	task automatic send_link(input logic [ldf_pkg::BYTE_W-1:0] b);
		if ($urandom_range(0, 99) < read_pct)
			send_read(pick_read_index());
		send_word(ldf_pkg::CMD_LINK, b, ldf_pkg::IDX_W'($urandom_range(0, IDX_TOP)));
	endtask

	task automatic send_queue();
		foreach (frame_q[i])
			send_link(frame_q[i]);
		frame_q.delete();
	endtask

	// Build a frame with a random body; oversized lengths carry no body and no end byte
	task automatic build_frame(input logic [ldf_pkg::BYTE_W-1:0] label, input int flen,
			input bit end_ok);
		logic [ldf_pkg::BYTE_W-1:0] eb;
		frame_q.delete();
		frame_q.push_back(start_mk);
		frame_q.push_back(label);
		frame_q.push_back(ldf_pkg::BYTE_W'(flen));
		frame_q.push_back(ldf_pkg::BYTE_W'(flen >> 8));
		if (flen <= MAX_BODY) begin
			repeat (flen) frame_q.push_back(rand_byte());
			eb = end_mk;
			if (!end_ok)
				do eb = rand_byte(); while (eb == end_mk);
			frame_q.push_back(eb);
		end
	endtask

	// Drop valid and wait until every result is in and the block has settled
	task automatic wait_quiet();
		items_ch.valid <= 1'b0;
		while (pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [ldf_pkg::CFG_IDX_W-1:0] idx,
			input logic [ldf_pkg::BYTE_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == ldf_pkg::REG_START_MARKER)
			start_mk = val;
		else
			end_mk = val;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// One random frame: mostly well formed, with noise, truncation and bad lengths mixed in
	task automatic random_frame();
		int sel;
		int flen;
		int n;
		logic [ldf_pkg::BYTE_W-1:0] nb;
		if ($urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				nb = rand_byte();
				if ($urandom_range(0, 9) != 0)
					while (nb == start_mk) nb = rand_byte();
				send_link(nb);
			end
		end
		sel = $urandom_range(0, 999);
		if (sel < 5)
			flen = $urandom_range(500, MAX_BODY);
		else if (sel < 45)
			flen = $urandom_range(13, 80);
		else if (sel < 100)
			flen = $urandom_range(MAX_BODY + 1, 65535);
		else if (sel < 200)
			flen = 0;
		else
			flen = $urandom_range(1, 12);
		build_frame(rand_byte(), flen, $urandom_range(0, 99) < 85);
		// cut the frame short now and then
		if ($urandom_range(0, 19) == 0 && frame_q.size() > 1) begin
			n = $urandom_range(1, frame_q.size() - 1);
			repeat (n) void'(frame_q.pop_back());
		end
		send_queue();
	endtask

	task automatic run_traffic(input int n_words);
		int target;
		target = words_sent + n_words;
		read_pct = 8;
		while (words_sent < target) begin
			if ($urandom_range(0, 19) == 0)
				idle_on = !idle_on;
			random_frame();
		end
		idle_on = 1'b1;
	endtask

	// Reset markers: noise, zero length, single-byte body, reads in and out of range
	task automatic test_reset_markers();
		read_pct = 0;
		send_link(8'h00);
		send_link(8'hFF);
		send_link(ldf_pkg::END_MARKER_RST);
		send_link(8'h7F);
		build_frame(8'hFF, 0, 1'b1);
		send_queue();
		build_frame(8'h00, 1, 1'b1);
		send_queue();
		send_read('0);
		send_read(ldf_pkg::IDX_W'(MAX_BODY));
		send_read(ldf_pkg::IDX_W'(IDX_TOP));
		wait_quiet();
	endtask

	// Longest body, oversized lengths, wrong end byte, start byte inside a frame
	task automatic test_edge_frames();
		read_pct = 0;
		build_frame(rand_byte(), MAX_BODY, 1'b1);
		send_queue();
		send_read('0);
		send_read(ldf_pkg::IDX_W'(MAX_BODY - 1));
		send_read(ldf_pkg::IDX_W'(512));
		// one past the limit, then an end byte that must be ignored
		build_frame(8'h55, MAX_BODY + 1, 1'b1);
		send_queue();
		send_link(end_mk);
		build_frame(8'hAA, 65535, 1'b1);
		send_queue();
		build_frame(8'h3C, 4, 1'b0);
		send_queue();
		// start byte as label, length and body bytes
		frame_q = '{start_mk, start_mk, 8'd3, 8'd0, start_mk, start_mk, end_mk, end_mk};
		send_queue();
		frame_q = '{start_mk, start_mk, start_mk, 8'd0};
		send_queue();
		repeat (126) send_link(start_mk);
		send_link(end_mk);
		// a read in the middle of a body leaves the parse alone
		frame_q = '{start_mk, 8'hC3, 8'd2, 8'd0, 8'h11};
		send_queue();
		send_read('0);
		send_link(8'h22);
		send_link(end_mk);
		wait_quiet();
	endtask

	// Run traffic under several marker settings, the extremes among them
	task automatic test_marker_settings();
		logic [ldf_pkg::BYTE_W-1:0] st_list [5];
		logic [ldf_pkg::BYTE_W-1:0] en_list [5];
		st_list = '{8'h00, 8'hFF, 8'h5A, rand_byte(), ldf_pkg::START_MARKER_RST};
		en_list = '{8'hFF, 8'h00, 8'h5A, rand_byte(), ldf_pkg::END_MARKER_RST};
		for (int i = 0; i < 5; i++) begin
			wait_quiet();
			write_reg(ldf_pkg::REG_START_MARKER, st_list[i]);
			write_reg(ldf_pkg::REG_END_MARKER, en_list[i]);
			settings_run++;
			run_traffic(90);
		end
		wait_quiet();
	endtask

	task automatic test_random_traffic();
		wait_quiet();
		write_reg(ldf_pkg::REG_END_MARKER, rand_byte());
		write_reg(ldf_pkg::REG_START_MARKER, rand_byte());
		settings_run++;
		run_traffic(160);
		wait_quiet();
	endtask

	// Receiver: ready follows one of four patterns, each drawn at random and kept for a random run
	initial begin : rx_stall
		int  mode;
		int  mode_left;
		int  hold;
		bit  lvl;
		mode      = 0;
		mode_left = 0;
		hold      = 0;
		lvl       = 1'b0;
		results_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			case (mode)
				0: results_ch.ready <= 1'b1;
				1: results_ch.ready <= ($urandom_range(0, 1) == 1);
				2: results_ch.ready <= (mode_left % 4 != 0);
				default: begin
					if (hold == 0) begin
						hold = $urandom_range(1, 12);
						lvl  = !lvl;
					end
					hold--;
					results_ch.ready <= lvl;
				end
			endcase
		end
	end

	// Compare each accepted result word with the oldest expectation
	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			got.kind   = results_ch.result_kind;
			got.label  = results_ch.frame_label;
			got.length = results_ch.frame_length;
			got.rbyte  = results_ch.read_byte;
			if (pending.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result: kind %0d label %0d length %0d byte %0d",
					$time, got.kind, got.label, got.length, got.rbyte);
			end else begin
				want = pending.pop_front();
				if (got !== want) begin
					err_count++;
					$display("%0t: mismatch: expected kind %0d label %0d length %0d byte %0d",
						$time, want.kind, want.label, want.length, want.rbyte);
					$display("%0t:           actual kind %0d label %0d length %0d byte %0d",
						$time, got.kind, got.label, got.length, got.rbyte);
				end
				if (want.kind == ldf_pkg::KIND_FRAME)
					frames_seen++;
				else
					reads_seen++;
			end
		end
	end

	// Sequence the tests
	initial begin
		err_count      = 0;
		words_sent     = 0;
		frames_seen    = 0;
		reads_seen     = 0;
		frames_dropped = 0;
		settings_run   = 1;
		burst_left     = 0;
		idle_on        = 1'b1;
		read_pct       = 0;
		start_mk       = ldf_pkg::START_MARKER_RST;
		end_mk         = ldf_pkg::END_MARKER_RST;
		ph             = ldf_pkg::PH_HUNT;
		lbl            = '0;
		len            = '0;
		cnt            = 0;
		foreach (body_mem[i]) begin
			body_mem[i] = '0;
			written[i]  = 1'b0;
		end
		arst_n              = 1'b0;
		items_ch.valid      = 1'b0;
		items_ch.command    = ldf_pkg::CMD_LINK;
		items_ch.rx_byte    = '0;
		items_ch.read_index = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = ldf_pkg::REG_START_MARKER;
		cfg_ch.data         = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_markers();
		test_edge_frames();
		test_marker_settings();
		test_random_traffic();

		repeat (8 * DRAIN_CYCLES) @(negedge clk);
		if (pending.size() != 0) begin
			err_count++;
			$display("%0t: %0d expected results never arrived", $time, pending.size());
		end
		$display("testbench: %0d words sent under %0d marker settings, %0d frames dropped",
			words_sent, settings_run, frames_dropped);
		$display("testbench: %0d frame results and %0d buffer reads checked",
			frames_seen, reads_seen);
		if (err_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

### files.f
sv/ldf_pkg.sv
sv/ldf_if.sv
sv/ldf_parser.sv
sv/ldf_body_ram.sv
sv/labeled_frame_deframer_unit.sv
dv/testbench.sv
